// ===== rtl/fts_pkg.sv =====
// Frame time statistics package: control word types and the microcode ROM.
// Used by frame_time_statistics; no dependencies.
package fts_pkg;

    typedef logic [3:0] step_t;

    typedef enum logic [3:0] {
        OP_TAKE,
        OP_ELAPSED,
        OP_TEST,
        OP_RING_SUB,
        OP_RING_ADD,
        OP_FRAME,
        OP_WIN_CHECK,
        OP_CLOSE,
        OP_MDIV_LOAD,
        OP_DIV_STEP,
        OP_MEAN_UPD,
        OP_ADIV_LOAD,
        OP_AVG_UPD,
        OP_EMIT,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_NO_EVENT,
        JC_REJECT,
        JC_NO_CLOSE,
        JC_DIV_MORE,
        JC_RING_EMPTY,
        JC_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    localparam step_t ST_WAIT      = 4'd0;
    localparam step_t ST_ELAPSED   = 4'd1;
    localparam step_t ST_TEST      = 4'd2;
    localparam step_t ST_RING_SUB  = 4'd3;
    localparam step_t ST_RING_ADD  = 4'd4;
    localparam step_t ST_FRAME     = 4'd5;
    localparam step_t ST_WIN_CHECK = 4'd6;
    localparam step_t ST_CLOSE     = 4'd7;
    localparam step_t ST_MDIV_LOAD = 4'd8;
    localparam step_t ST_MDIV_RUN  = 4'd9;
    localparam step_t ST_MEAN_UPD  = 4'd10;
    localparam step_t ST_ADIV_LOAD = 4'd11;
    localparam step_t ST_ADIV_RUN  = 4'd12;
    localparam step_t ST_AVG_UPD   = 4'd13;
    localparam step_t ST_EMIT      = 4'd14;

    localparam int AVG_W  = 24;
    localparam int RATE_W = 16;
    localparam int MEAN_W = 24;
    localparam int TICK_W = 32;
    localparam int OUT_W  = AVG_W + 3 * RATE_W + MEAN_W;

    localparam logic [23:0] ACCEPT_Q8 = 24'd256000;

    function automatic uword_t ucode(input step_t step);
        uword_t w;
        unique case (step)
            ST_WAIT:      w = '{OP_TAKE,      JC_NO_EVENT,   ST_WAIT};
            ST_ELAPSED:   w = '{OP_ELAPSED,   JC_NONE,       ST_WAIT};
            ST_TEST:      w = '{OP_TEST,      JC_REJECT,     ST_FRAME};
            ST_RING_SUB:  w = '{OP_RING_SUB,  JC_NONE,       ST_WAIT};
            ST_RING_ADD:  w = '{OP_RING_ADD,  JC_NONE,       ST_WAIT};
            ST_FRAME:     w = '{OP_FRAME,     JC_NONE,       ST_WAIT};
            ST_WIN_CHECK: w = '{OP_WIN_CHECK, JC_NO_CLOSE,   ST_ADIV_LOAD};
            ST_CLOSE:     w = '{OP_CLOSE,     JC_NONE,       ST_WAIT};
            ST_MDIV_LOAD: w = '{OP_MDIV_LOAD, JC_NONE,       ST_WAIT};
            ST_MDIV_RUN:  w = '{OP_DIV_STEP,  JC_DIV_MORE,   ST_MDIV_RUN};
            ST_MEAN_UPD:  w = '{OP_MEAN_UPD,  JC_NONE,       ST_WAIT};
            ST_ADIV_LOAD: w = '{OP_ADIV_LOAD, JC_RING_EMPTY, ST_EMIT};
            ST_ADIV_RUN:  w = '{OP_DIV_STEP,  JC_DIV_MORE,   ST_ADIV_RUN};
            ST_AVG_UPD:   w = '{OP_AVG_UPD,   JC_NONE,       ST_WAIT};
            ST_EMIT:      w = '{OP_EMIT,      JC_OUT_FULL,   ST_EMIT};
            default:      w = '{OP_NOP,       JC_ALWAYS,     ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/fts_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module fts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/frame_time_statistics.sv =====
// Frame time statistics: microcoded sequencer over a small datapath.
// Depends on fts_pkg and fts_ram.
//
// Usage: each beat on the s_axis channel is a frame-end event carrying a
// 32-bit millisecond timestamp. While the enable register (cfg_wr_en /
// cfg_wr_data) is set, each event yields one m_axis beat: smoothed frame
// time (Q.8 ms), latched frame rate, min, max and running mean rate (Q.8),
// with tuser[0] set when the event closed a WINDOW_MS window. With enable
// clear, events are taken and dropped.
// Timing: an event is taken only in the wait step, then runs through the
// microcode program; the next event is taken after the emit step is done.
// One restoring divider, one quotient bit per cycle, does the mean-rate
// and average divides, DW = 16 + clog2(SAMPLES) + 8 bits (30 by default).
// A window close adds the mean divide; rejected samples skip the ring.
// The result sits in an output register; if the receiver stalls, the next
// event is still taken and processed, and only its emit step waits.
// Reset (aresetn low, synchronous) clears all statistics, min rate to all
// ones; the sample ring needs no clearing.
module frame_time_statistics #(
    parameter int SAMPLES   = 64,
    parameter int WINDOW_MS = 1000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] tick_ms
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [23:0] avg_frame_ms_q8, [39:24] frame_rate, [55:40] min_rate,
    // [71:56] max_rate, [95:72] mean_rate_q8
    output logic [95:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser    // [0] rate_updated
);

    localparam int IDXW = $clog2(SAMPLES);
    localparam int CNTW = $clog2(SAMPLES + 1);
    localparam int SUMW = 16 + IDXW;
    localparam int DW   = (SUMW + 8 > 24) ? SUMW + 8 : 24;
    localparam int DCW  = $clog2(DW + 1);
    localparam logic [31:0] WIN_Q8 = 32'(WINDOW_MS * 256);

    fts_pkg::step_t  step_reg, step_next;
    fts_pkg::uword_t uw;

    logic                 enable_reg;
    logic [31:0]          tick_reg;
    logic [31:0]          last_tick_reg;
    logic [15:0]          elapsed_reg;
    logic [IDXW-1:0]      ring_index_reg;
    logic [CNTW-1:0]      ring_count_reg;
    logic [SUMW-1:0]      ring_sum_reg;
    logic [23:0]          avg_reg;
    logic [15:0]          frames_reg;
    logic [31:0]          accum_reg;
    logic [15:0]          rate_reg;
    logic [15:0]          rate_min_reg;
    logic [15:0]          rate_max_reg;
    logic [23:0]          mean_reg;
    logic [31:0]          mean_count_reg;
    logic                 mean_up_reg;
    logic                 updated_reg;

    logic [31:0]          div_rem_reg;
    logic [DW-1:0]        div_q_reg;
    logic [31:0]          div_den_reg;
    logic [DCW-1:0]       div_cnt_reg;

    logic                 m_valid_reg;
    logic [95:0]          m_data_reg;
    logic                 m_user_reg;

    logic [15:0]          ram_rd_data;
    logic                 ram_wr_en;

    logic                 s_accept;
    logic                 out_full;
    logic [31:0]          tick_diff;
    logic [23:0]          e_q8;
    logic [23:0]          gap_dist;
    logic                 sample_ok;
    logic [32:0]          accum_sum;
    logic                 close_hit;
    logic [23:0]          target;
    logic [31:0]          count_inc;
    logic [32:0]          div_shift;
    logic                 div_ge;
    logic                 jump;

    assign uw            = fts_pkg::ucode(step_reg);
    assign s_axis_tready = (step_reg == fts_pkg::ST_WAIT);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_full      = m_valid_reg && !m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    assign tick_diff = tick_reg - last_tick_reg;
    assign e_q8      = {elapsed_reg, 8'h00};
    assign gap_dist  = (e_q8 >= avg_reg) ? (e_q8 - avg_reg) : (avg_reg - e_q8);
    assign sample_ok = (gap_dist < fts_pkg::ACCEPT_Q8);
    assign accum_sum = {1'b0, accum_reg} + {9'd0, avg_reg};
    assign close_hit = (accum_reg > WIN_Q8);
    assign target    = {rate_reg, 8'h00};
    assign count_inc = mean_count_reg + 32'd1;
    assign div_shift = {1'b0, div_rem_reg} << 1 | {32'd0, div_q_reg[DW-1]};
    assign div_ge    = (div_shift >= {1'b0, div_den_reg});
    assign ram_wr_en = (uw.op == fts_pkg::OP_RING_ADD);

    always_comb begin
        unique case (uw.cond)
            fts_pkg::JC_NONE:       jump = 1'b0;
            fts_pkg::JC_ALWAYS:     jump = 1'b1;
            fts_pkg::JC_NO_EVENT:   jump = !(s_accept && enable_reg);
            fts_pkg::JC_REJECT:     jump = !sample_ok;
            fts_pkg::JC_NO_CLOSE:   jump = !close_hit;
            fts_pkg::JC_DIV_MORE:   jump = (div_cnt_reg != DCW'(1));
            fts_pkg::JC_RING_EMPTY: jump = (ring_count_reg == '0);
            fts_pkg::JC_OUT_FULL:   jump = out_full;
            default:                jump = 1'b0;
        endcase
        if (jump) begin
            step_next = uw.target;
        end else if (step_reg == fts_pkg::ST_EMIT) begin
            step_next = fts_pkg::ST_WAIT;
        end else begin
            step_next = step_reg + 4'd1;
        end
    end

    fts_ram #(
        .WIDTH (16),
        .DEPTH (SAMPLES)
    ) u_ring (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ring_index_reg),
        .wr_data (elapsed_reg),
        .rd_addr (ring_index_reg),
        .rd_data (ram_rd_data)
    );

    // divider payload, tick capture and output beat register, no reset
    always_ff @(posedge aclk) begin
        if (uw.op == fts_pkg::OP_TAKE && s_accept) begin
            tick_reg <= s_axis_tdata;
        end
        unique case (uw.op)
            fts_pkg::OP_MDIV_LOAD: begin
                div_q_reg   <= DW'((target >= mean_reg) ? (target - mean_reg)
                                                        : (mean_reg - target));
                div_den_reg <= mean_count_reg;
                div_rem_reg <= '0;
            end
            fts_pkg::OP_ADIV_LOAD: begin
                div_q_reg   <= DW'({ring_sum_reg, 8'h00});
                div_den_reg <= 32'(ring_count_reg);
                div_rem_reg <= '0;
            end
            fts_pkg::OP_DIV_STEP: begin
                div_rem_reg <= div_ge ? 32'(div_shift - {1'b0, div_den_reg})
                                      : div_shift[31:0];
                div_q_reg   <= {div_q_reg[DW-2:0], div_ge};
            end
            default: begin
            end
        endcase
        if (uw.op == fts_pkg::OP_EMIT && !out_full) begin
            m_data_reg <= {mean_reg, rate_max_reg, rate_min_reg, rate_reg, avg_reg};
            m_user_reg <= updated_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= fts_pkg::ST_WAIT;
            enable_reg     <= 1'b0;
            last_tick_reg  <= '0;
            elapsed_reg    <= '0;
            ring_index_reg <= '0;
            ring_count_reg <= '0;
            ring_sum_reg   <= '0;
            avg_reg        <= '0;
            frames_reg     <= '0;
            accum_reg      <= '0;
            rate_reg       <= '0;
            rate_min_reg   <= '1;
            rate_max_reg   <= '0;
            mean_reg       <= '0;
            mean_count_reg <= '0;
            mean_up_reg    <= 1'b0;
            updated_reg    <= 1'b0;
            div_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (cfg_wr_en) begin
                enable_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_axis_tready && uw.op != fts_pkg::OP_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (uw.op)
                fts_pkg::OP_ELAPSED: begin
                    if (last_tick_reg != '0) begin
                        elapsed_reg <= (|tick_diff[31:16]) ? 16'hFFFF : tick_diff[15:0];
                    end else begin
                        elapsed_reg <= '0;
                    end
                    last_tick_reg <= tick_reg;
                end
                fts_pkg::OP_RING_SUB: begin
                    if (ring_count_reg == CNTW'(SAMPLES)) begin
                        ring_sum_reg <= ring_sum_reg - SUMW'(ram_rd_data);
                    end
                end
                fts_pkg::OP_RING_ADD: begin
                    ring_sum_reg   <= ring_sum_reg + SUMW'(elapsed_reg);
                    ring_index_reg <= (ring_index_reg == IDXW'(SAMPLES - 1))
                                      ? '0 : ring_index_reg + IDXW'(1);
                    if (ring_count_reg != CNTW'(SAMPLES)) begin
                        ring_count_reg <= ring_count_reg + CNTW'(1);
                    end
                end
                fts_pkg::OP_FRAME: begin
                    if (frames_reg != 16'hFFFF) begin
                        frames_reg <= frames_reg + 16'd1;
                    end
                    accum_reg <= accum_sum[32] ? 32'hFFFF_FFFF : accum_sum[31:0];
                end
                fts_pkg::OP_WIN_CHECK: begin
                    updated_reg <= close_hit;
                end
                fts_pkg::OP_CLOSE: begin
                    rate_reg   <= frames_reg;
                    frames_reg <= '0;
                    accum_reg  <= '0;
                    if (frames_reg < rate_min_reg) begin
                        rate_min_reg <= frames_reg;
                    end
                    if (frames_reg > rate_max_reg) begin
                        rate_max_reg <= frames_reg;
                    end
                    if (count_inc == '0) begin
                        mean_reg       <= '0;
                        mean_count_reg <= 32'd1;
                    end else begin
                        mean_count_reg <= count_inc;
                    end
                end
                fts_pkg::OP_MDIV_LOAD: begin
                    mean_up_reg <= (target >= mean_reg);
                    div_cnt_reg <= DCW'(DW);
                end
                fts_pkg::OP_ADIV_LOAD: begin
                    div_cnt_reg <= DCW'(DW);
                end
                fts_pkg::OP_DIV_STEP: begin
                    div_cnt_reg <= div_cnt_reg - DCW'(1);
                end
                fts_pkg::OP_MEAN_UPD: begin
                    mean_reg <= mean_up_reg ? mean_reg + div_q_reg[23:0]
                                            : mean_reg - div_q_reg[23:0];
                end
                fts_pkg::OP_AVG_UPD: begin
                    avg_reg <= div_q_reg[23:0];
                end
                fts_pkg::OP_EMIT: begin
                    if (!out_full) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    a_emit_from_program: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(step_reg == fts_pkg::ST_EMIT))
        else $error("output beat raised outside the emit step");

    a_minmax_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (mean_count_reg != '0) |-> (rate_min_reg <= rate_max_reg))
        else $error("min rate above max rate after a window closed");

    a_ring_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (ring_count_reg <= CNTW'(SAMPLES)) && (ring_index_reg <= IDXW'(SAMPLES - 1)))
        else $error("ring count or index out of range");

    a_div_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_cnt_reg != '0) |->
            (step_reg == fts_pkg::ST_MDIV_RUN || step_reg == fts_pkg::ST_ADIV_RUN))
        else $error("divider active outside a divide step");

endmodule

// ===== sim/frame_time_statistics_tb.sv =====
// Self-checking testbench for frame_time_statistics: frame-end events go in,
// every output beat is checked field by field against an in-bench predictor.
// Depends on fts_pkg and the frame_time_statistics RTL.
module frame_time_statistics_tb;

    localparam int          WINDOW_MS   = 1000;
    localparam logic [31:0] WINDOW_Q8   = WINDOW_MS * 256;
    localparam int          RING_DEPTH  = 64;
    localparam int          TAIL_CYCLES = 150;
    localparam int          STALL_LIMIT = 5000;

    typedef struct packed {
        logic                      closed;
        logic [fts_pkg::OUT_W-1:0] stats;
    } stats_beat_t;

    logic                       aclk          = 1'b0;
    logic                       aresetn       = 1'b0;
    logic                       cfg_wr_en     = 1'b0;
    logic                       cfg_wr_data   = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [fts_pkg::TICK_W-1:0] s_axis_tdata  = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [fts_pkg::OUT_W-1:0]  m_axis_tdata;
    logic [0:0]                 m_axis_tuser;

    frame_time_statistics uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    bit                         fs_enable   = 1'b0;
    logic [31:0]                fs_last_tick = '0;
    logic [15:0]                fs_ring [RING_DEPTH];
    logic [5:0]                 fs_wr_ptr   = '0;
    logic [6:0]                 fs_fill     = '0;
    logic [21:0]                fs_sum      = '0;
    logic [fts_pkg::AVG_W-1:0]  fs_avg_q8   = '0;
    logic [15:0]                fs_frames   = '0;
    logic [31:0]                fs_accum    = '0;
    logic [fts_pkg::RATE_W-1:0] fs_rate     = '0;
    logic [fts_pkg::RATE_W-1:0] fs_rate_min = '1;
    logic [fts_pkg::RATE_W-1:0] fs_rate_max = '0;
    logic [fts_pkg::MEAN_W-1:0] fs_mean_q8  = '0;
    logic [31:0]                fs_windows  = '0;

    logic [fts_pkg::TICK_W-1:0] tick_pending [$];
    stats_beat_t                stats_due [$];
    logic [31:0]                stream_ms;
    int                         errors = 0;
    int                         src_idle_pct = 20;
    int                         snk_idle_pct = 20;
    int                         quiet_cycles = 0;

    function automatic bit advance_frame_stats(input logic [31:0] tick,
                                               output stats_beat_t beat);
        logic [31:0]     gap;
        logic [31:0]     gap_q8;
        logic [31:0]     gap_dist;
        logic [32:0]     acc_sum;
        logic [31:0]     target;
        logic [31:0]     q;
        logic [5:0]      slot;
        longint unsigned num;
        bit              closed;
        closed = 1'b0;
        beat   = '0;
        if (!fs_enable) return 1'b0;
        gap = '0;
        if (fs_last_tick != 0) begin
            gap = tick - fs_last_tick;
            if (gap > 32'h0000_FFFF) gap = 32'h0000_FFFF;
        end
        fs_last_tick = tick;
        gap_q8 = gap << 8;
        gap_dist = (gap_q8 >= {8'h00, fs_avg_q8}) ? gap_q8 - {8'h00, fs_avg_q8}
                                                  : {8'h00, fs_avg_q8} - gap_q8;
        if (gap_dist < {8'h00, fts_pkg::ACCEPT_Q8}) begin
            slot = fs_wr_ptr;
            if (fs_fill >= RING_DEPTH) fs_sum = fs_sum - fs_ring[slot];
            fs_ring[slot] = gap[15:0];
            fs_sum = fs_sum + gap[15:0];
            fs_wr_ptr = slot + 6'd1;
            if (fs_fill < RING_DEPTH) fs_fill = fs_fill + 7'd1;
        end
        if (fs_frames != 16'hFFFF) fs_frames = fs_frames + 16'd1;
        acc_sum = {1'b0, fs_accum} + {9'h000, fs_avg_q8};
        fs_accum = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
        if (fs_accum > WINDOW_Q8) begin
            closed = 1'b1;
            fs_rate = fs_frames;
            fs_frames = '0;
            fs_accum = '0;
            if (fs_rate < fs_rate_min) fs_rate_min = fs_rate;
            if (fs_rate > fs_rate_max) fs_rate_max = fs_rate;
            fs_windows = fs_windows + 32'd1;
            if (fs_windows == 0) begin
                fs_mean_q8 = '0;
                fs_windows = 32'd1;
            end
            target = {8'h00, fs_rate, 8'h00};
            if (target >= {8'h00, fs_mean_q8}) begin
                q = (target - {8'h00, fs_mean_q8}) / fs_windows;
                fs_mean_q8 = fs_mean_q8 + q[fts_pkg::MEAN_W-1:0];
            end else begin
                q = ({8'h00, fs_mean_q8} - target) / fs_windows;
                fs_mean_q8 = fs_mean_q8 - q[fts_pkg::MEAN_W-1:0];
            end
        end
        if (fs_fill != 0) begin
            num = 64'(fs_sum);
            num = (num << 8) / fs_fill;
            fs_avg_q8 = num[fts_pkg::AVG_W-1:0];
        end else begin
            fs_avg_q8 = '0;
        end
        beat.closed = closed;
        beat.stats  = {fs_mean_q8, fs_rate_max, fs_rate_min, fs_rate, fs_avg_q8};
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // event driver: predicts on every accepted beat
    always @(posedge aclk) begin
        stats_beat_t beat;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (advance_frame_stats(s_axis_tdata, beat)) stats_due.push_back(beat);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tick_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tdata  <= tick_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        stats_beat_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (stats_due.size() == 0) begin
                    report_mismatch("result beat with no event pending");
                end else begin
                    want = stats_due.pop_front();
                    check_field("avg_frame_ms_q8", 32'(m_axis_tdata[23:0]),
                                32'(want.stats[23:0]));
                    check_field("frame_rate", 32'(m_axis_tdata[39:24]),
                                32'(want.stats[39:24]));
                    check_field("min_rate", 32'(m_axis_tdata[55:40]),
                                32'(want.stats[55:40]));
                    check_field("max_rate", 32'(m_axis_tdata[71:56]),
                                32'(want.stats[71:56]));
                    check_field("mean_rate_q8", 32'(m_axis_tdata[95:72]),
                                32'(want.stats[95:72]));
                    check_field("rate_updated", 32'(m_axis_tuser[0]), 32'(want.closed));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("frame_time_statistics_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_enable(input bit value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        fs_enable = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // wait until every event is taken and every result is in
    task automatic settle(input bit with_tail);
        do @(negedge aclk);
        while (tick_pending.size() != 0 || s_axis_tvalid || stats_due.size() != 0);
        if (with_tail) repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    // steady frame streams with jitter, plus occasional jumps, rewinds and zeros
    task automatic queue_random_chunk(input int count);
        int period;
        int jitter;
        int run_len;
        int n;
        int pick;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(9);
            if (pick == 0) stream_ms = $urandom();
            else if (pick == 1) stream_ms = 32'hFFFF_FFFF - $urandom_range(2000);
            period  = ($urandom_range(7) == 0) ? $urandom_range(200, 1500)
                                               : $urandom_range(2, 120);
            jitter  = $urandom_range(period / 4);
            run_len = $urandom_range(10, 60);
            for (int i = 0; i < run_len && n < count; i++) begin
                if ($urandom_range(19) == 0) begin
                    case ($urandom_range(3))
                        0:       stream_ms = $urandom();
                        1:       stream_ms = stream_ms + $urandom_range(900, 80000);
                        2:       stream_ms = stream_ms - $urandom_range(1, 500);
                        default: stream_ms = 32'h0000_0000;
                    endcase
                end else begin
                    stream_ms = stream_ms + period + $urandom_range(2 * jitter) - jitter;
                end
                tick_pending.push_back(stream_ms);
                n++;
            end
            if ($urandom_range(3) == 0) settle(1'b0);
        end
    endtask

    initial begin
        stream_ms = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // disabled: events are dropped
        write_enable(1'b0);
        tick_pending.push_back(32'hFFFF_FFFF);
        tick_pending.push_back(32'h0000_0000);
        tick_pending.push_back(32'h1234_5678);
        settle(1'b1);
        write_enable(1'b1);

        // first event, stored zero, acceptance edge, rewind, wrap, saturation
        tick_pending.push_back(32'd0);
        tick_pending.push_back(32'd0);
        tick_pending.push_back(32'd100);
        tick_pending.push_back(32'd1100);
        tick_pending.push_back(32'd2099);
        tick_pending.push_back(32'd2049);
        tick_pending.push_back(32'hFFFF_FFF0);
        tick_pending.push_back(32'h0000_0010);
        tick_pending.push_back(32'h0001_0010);
        tick_pending.push_back(32'h0002_000F);
        tick_pending.push_back(32'hFFFF_FFFF);
        stream_ms = 32'h0000_0027;
        tick_pending.push_back(stream_ms);
        for (int i = 0; i < 12; i++) begin
            stream_ms = stream_ms + 32'd40;
            tick_pending.push_back(stream_ms);
        end
        settle(1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            src_idle_pct = (phase == 2) ? 0 : 20;
            snk_idle_pct = (phase == 2) ? 0 : 20;
            queue_random_chunk(155);
            settle(1'b1);
            write_enable(1'b0);
            for (int i = 0; i < 4; i++) tick_pending.push_back($urandom());
            settle(1'b1);
            write_enable(1'b1);
        end

        settle(1'b1);
        if (errors == 0 && stats_due.size() == 0) begin
            $display("frame_time_statistics_tb: done, clean");
        end else begin
            $display("frame_time_statistics_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== frame_time_statistics.f =====
rtl/fts_pkg.sv
rtl/fts_ram.sv
rtl/frame_time_statistics.sv
sim/frame_time_statistics_tb.sv
